// ===== design/assert_macros.svh =====
// Assertion macros used by the RTL top level of the frame receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define AST_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: invariant violated");
// Consequent must hold in the cycle after the antecedent.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check violated");
`else
`define AST_ALWAYS(label, clk, rst_n, prop)
`define AST_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/hsfr_pkg.sv =====
// Package: shared types and constants of the header-sum frame receiver.
package hsfr_pkg;

    localparam int BYTE_W = 8;
    localparam int IDX_W  = 4;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [IDX_W-1:0]  idx_t;

    localparam byte_t HEADER_RESET = 8'hCC;

endpackage

// ===== design/hsfr_frame_mem.sv =====
// Frame store: one write port, one registered read port.
module hsfr_frame_mem
    import hsfr_pkg::*;
#(
    parameter int DEPTH  = 14,
    parameter int ADDR_W = 4
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  byte_t             wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output byte_t             rd_data
);

    byte_t mem_reg [DEPTH];
    byte_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/header_sum_frame_receiver.sv =====
// Top level: header-triggered fixed-length frame receiver with 8-bit sum check.
// A byte is taken on in_valid with in_stall low; in_stall is low while hunting or collecting.
// A good checksum byte starts readout: each frame byte is read from the store in FETCH,
// then presented in SHOW, as the store has a single read port; in_stall stays high
// through the readout, also while out_stall holds a byte. Bad frames cost nothing.
// Async active-low reset: hunting state, sum and count cleared, header = 0xCC.
`include "assert_macros.svh"

module header_sum_frame_receiver
    import hsfr_pkg::*;
#(
    parameter int FRAME_LEN = 14
)
(
    input  logic  clk,
    input  logic  rst_n,
    // configuration: header byte value
    input  logic  cfg_write_en,
    input  byte_t cfg_write_data,
    // receive channel
    input  logic  in_valid,
    output logic  in_stall,
    input  byte_t rx_byte,
    // frame output channel
    output logic  out_valid,
    input  logic  out_stall,
    output byte_t frame_byte,
    output idx_t  byte_index,
    output logic  last_byte
);

    localparam int ADDR_W = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
    localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(FRAME_LEN - 1);

    // HUNT: waiting for header; BODY: collecting; FETCH/SHOW: store readout
    typedef enum logic [1:0] {
        ST_HUNT,
        ST_BODY,
        ST_FETCH,
        ST_SHOW
    } state_t;

    state_t            state_reg, state_next;
    byte_t             header_reg, header_next;
    byte_t             sum_reg, sum_next;
    // shared counter: write position while collecting, read position on readout
    logic [ADDR_W-1:0] cnt_reg, cnt_next;

    logic  in_xfer;
    logic  out_xfer;
    logic  at_last;
    logic  sum_end;
    logic  hit;
    byte_t cmp_ref;
    byte_t add_base;
    byte_t add_out;
    logic  mem_wr_en;
    logic  mem_rd_en;
    byte_t mem_rd_data;

    assign in_stall = !((state_reg == ST_HUNT) || (state_reg == ST_BODY));
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;
    assign at_last  = (cnt_reg == LAST_POS);
    // checksum byte taken this cycle
    assign sum_end  = in_xfer && (state_reg == ST_BODY) && at_last;

    // shared compare: header match while hunting, checksum match on last byte
    assign cmp_ref = (state_reg == ST_HUNT) ? header_reg : sum_reg;
    assign hit     = (rx_byte == cmp_ref);

    // shared adder: the header starts a fresh sum
    assign add_base = (state_reg == ST_HUNT) ? '0 : sum_reg;
    assign add_out  = add_base + rx_byte;

    assign mem_wr_en = in_xfer && ((state_reg == ST_BODY) || hit);
    assign mem_rd_en = (state_reg == ST_FETCH);

    hsfr_frame_mem #(
        .DEPTH  (FRAME_LEN),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (cnt_reg),
        .wr_data (rx_byte),
        .rd_en   (mem_rd_en),
        .rd_addr (cnt_reg),
        .rd_data (mem_rd_data)
    );

    always_comb
    begin
        state_next  = state_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        header_next = cfg_write_en ? cfg_write_data : header_reg;
        unique case (state_reg)
            ST_HUNT:
            begin
                if (in_xfer && hit)
                begin
                    // header stored at position 0
                    sum_next   = add_out;
                    cnt_next   = ADDR_W'(1);
                    state_next = ST_BODY;
                end
            end
            ST_BODY:
            begin
                if (in_xfer)
                begin
                    if (at_last)
                    begin
                        cnt_next   = '0;
                        sum_next   = '0;
                        state_next = hit ? ST_FETCH : ST_HUNT;
                    end
                    else
                    begin
                        sum_next = add_out;
                        cnt_next = cnt_reg + ADDR_W'(1);
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (out_xfer)
                begin
                    if (at_last)
                    begin
                        cnt_next   = '0;
                        state_next = ST_HUNT;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + ADDR_W'(1);
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_HUNT;
            header_reg <= HEADER_RESET;
            sum_reg    <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            header_reg <= header_next;
            sum_reg    <= sum_next;
            cnt_reg    <= cnt_next;
        end
    end

    // output held from the store read register; no read while presenting
    assign out_valid  = (state_reg == ST_SHOW);
    assign frame_byte = mem_rd_data;
    assign byte_index = IDX_W'(cnt_reg);
    assign last_byte  = at_last;

    // never take a byte while a frame byte is on offer
    `AST_ALWAYS(a_no_rx_during_out, clk, rst_n, !out_valid || in_stall)
    // last frame byte taken: back to hunting
    `AST_NEXT(a_last_to_hunt, clk, rst_n, out_xfer && last_byte, state_reg == ST_HUNT)
    // bad checksum drops the frame without output
    `AST_NEXT(a_bad_sum_drop, clk, rst_n, sum_end && !hit, state_reg == ST_HUNT && !out_valid)
    // good checksum starts readout at position 0
    `AST_NEXT(a_good_sum_read, clk, rst_n, sum_end && hit, state_reg == ST_FETCH && cnt_reg == '0)
    // counter stays inside the frame
    `AST_ALWAYS(a_cnt_range, clk, rst_n, cnt_reg <= LAST_POS)

endmodule
